>>> rtl/lfu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants of the LFU cache
// Default sizes, operation codes, cell commands and controller states.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned DefEntries   = 64;
  localparam int unsigned DefKeyBits   = 16;
  localparam int unsigned DefValueBits = 32;
  localparam int unsigned DefCountBits = 16;

  localparam int unsigned CapBits      = 7;
  localparam int unsigned ReadBits     = 32;
  localparam int unsigned ApbAddrBits  = 3;
  localparam logic [ApbAddrBits-1:0] AddrCapacity = 3'd0;
  localparam logic [CapBits-1:0]     CapReset     = 7'd64;

  typedef enum logic {
    OP_PUT = 1'b0,
    OP_GET = 1'b1
  } op_e;

  // command broadcast to every cell in the update cycle
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_TOUCH  = 2'd1,
    CMD_INSERT = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_APPLY = 2'd2,
    ST_RESP  = 2'd3
  } state_e;

endpackage
`default_nettype wire

>>> rtl/lfu_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cell: one cache entry of the cell row
// Holds key, value, use count and recency rank; merges itself into the scan
// word from its left neighbor and registers it for the right neighbor.
// ----------------------------------------------------------------------------
module lfu_cell #(
  parameter int unsigned ENTRIES    = lfu_pkg::DefEntries,
  parameter int unsigned KEY_BITS   = lfu_pkg::DefKeyBits,
  parameter int unsigned VALUE_BITS = lfu_pkg::DefValueBits,
  parameter int unsigned COUNT_BITS = lfu_pkg::DefCountBits,
  parameter int unsigned IDX        = 0,
  localparam int unsigned IdxW      = $clog2(ENTRIES)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [KEY_BITS-1:0]   key_i,
  // scan word in
  input  wire logic                  hit_i,
  input  wire logic [IdxW-1:0]       hit_idx_i,
  input  wire logic [IdxW-1:0]       hit_rank_i,
  input  wire logic [VALUE_BITS-1:0] hit_value_i,
  input  wire logic                  vic_ok_i,
  input  wire logic [IdxW-1:0]       vic_idx_i,
  input  wire logic [COUNT_BITS-1:0] vic_count_i,
  input  wire logic [IdxW-1:0]       vic_rank_i,
  input  wire logic                  free_ok_i,
  input  wire logic [IdxW-1:0]       free_idx_i,
  // scan word out
  output logic                       hit_o,
  output logic [IdxW-1:0]            hit_idx_o,
  output logic [IdxW-1:0]            hit_rank_o,
  output logic [VALUE_BITS-1:0]      hit_value_o,
  output logic                       vic_ok_o,
  output logic [IdxW-1:0]            vic_idx_o,
  output logic [COUNT_BITS-1:0]      vic_count_o,
  output logic [IdxW-1:0]            vic_rank_o,
  output logic                       free_ok_o,
  output logic [IdxW-1:0]            free_idx_o,
  // update command
  input  wire lfu_pkg::cmd_e         cmd_i,
  input  wire logic                  wr_value_i,
  input  wire logic                  evict_i,
  input  wire logic [IdxW-1:0]       tgt_idx_i,
  input  wire logic [IdxW-1:0]       tgt_rank_i,
  input  wire logic [IdxW-1:0]       ev_idx_i,
  input  wire logic [IdxW-1:0]       ev_rank_i,
  input  wire logic [IdxW-1:0]       slot_idx_i,
  input  wire logic [VALUE_BITS-1:0] new_value_i
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(IDX);

  logic                  valid_q, valid_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [IdxW-1:0]       rank_q, rank_d;
  logic                  match, take_vic, is_vic;

  // merge this entry into the scan word
  assign match    = valid_q && (key_q == key_i) && !hit_i;
  assign take_vic = valid_q && (!vic_ok_i || (count_q < vic_count_i) ||
                    ((count_q == vic_count_i) && (rank_q > vic_rank_i)));

  always_ff @(posedge clk_i) begin
    hit_o       <= hit_i | match;
    hit_idx_o   <= match ? MyIdx : hit_idx_i;
    hit_rank_o  <= match ? rank_q : hit_rank_i;
    hit_value_o <= match ? value_q : hit_value_i;
    vic_ok_o    <= vic_ok_i | take_vic;
    vic_idx_o   <= take_vic ? MyIdx : vic_idx_i;
    vic_count_o <= take_vic ? count_q : vic_count_i;
    vic_rank_o  <= take_vic ? rank_q : vic_rank_i;
    free_ok_o   <= free_ok_i | !valid_q;
    free_idx_o  <= (!valid_q && !free_ok_i) ? MyIdx : free_idx_i;
  end

  // entry update
  assign is_vic = evict_i && (ev_idx_i == MyIdx);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    count_d = count_q;
    rank_d  = rank_q;
    unique case (cmd_i)
      lfu_pkg::CMD_TOUCH: begin
        if (tgt_idx_i == MyIdx) begin
          rank_d = '0;
          if (count_q != '1) count_d = count_q + 1'b1;
          if (wr_value_i) value_d = new_value_i;
        end else if (valid_q && (rank_q < tgt_rank_i)) begin
          rank_d = rank_q + 1'b1;
        end
      end
      lfu_pkg::CMD_INSERT: begin
        if (slot_idx_i == MyIdx) begin
          valid_d = 1'b1;
          key_d   = key_i;
          value_d = new_value_i;
          count_d = COUNT_BITS'(1);
          rank_d  = '0;
        end else if (is_vic) begin
          valid_d = 1'b0;
        end else if (valid_q) begin
          if (!(evict_i && (rank_q > ev_rank_i))) rank_d = rank_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
    count_q <= count_d;
    rank_q  <= rank_d;
  end

endmodule
`default_nettype wire

>>> rtl/lfu_cache_lru_tiebreak.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak: LFU key/value cache with LRU tie-break
// A row of entry cells scanned by a word that moves one cell per cycle,
// followed by a broadcast update of every cell.
// ----------------------------------------------------------------------------
// channel   direction  fields
// s_axis    in         tuser: opcode; tdata: key, value (from bit 0 up)
// m_axis    out        tuser: hit; tdata: read_value
// apb       in/out     capacity_in_use at address 0
//
// An item is accepted, its scan word passes through the cell row and a
// broadcast update is applied; a get then places its result word.
// Items are taken one at a time, only while the controller is idle.
// A stalled result word holds the controller until taken.
// Reset clears all valid bits and occupancy at once; no clearing pass.
module lfu_cache_lru_tiebreak #(
  parameter int unsigned ENTRIES    = lfu_pkg::DefEntries,
  parameter int unsigned KEY_BITS   = lfu_pkg::DefKeyBits,
  parameter int unsigned VALUE_BITS = lfu_pkg::DefValueBits,
  parameter int unsigned COUNT_BITS = lfu_pkg::DefCountBits,
  localparam int unsigned InW       = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [InW-1:0]                  s_axis_tdata,  // key, value
  input  wire logic                            s_axis_tuser,  // opcode
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [lfu_pkg::ReadBits-1:0]         m_axis_tdata,  // read_value
  output logic                                 m_axis_tuser,  // hit
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lfu_pkg::ApbAddrBits-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned OccW = $clog2(ENTRIES + 1);
  localparam int unsigned CmpW = (OccW > lfu_pkg::CapBits) ? OccW : lfu_pkg::CapBits;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);
  localparam logic [CmpW-1:0] MaxCap  = CmpW'(ENTRIES);

  // configuration register
  logic [lfu_pkg::CapBits-1:0] cap_q;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == lfu_pkg::AddrCapacity);
  assign prdata = (paddr == lfu_pkg::AddrCapacity) ? 32'(cap_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lfu_pkg::CapReset;
    end else if (cfg_wr) begin
      cap_q <= pwdata[lfu_pkg::CapBits-1:0];
    end
  end

  // controller state
  lfu_pkg::state_e       state_q, state_d;
  logic [IdxW-1:0]       cnt_q, cnt_d;
  logic [OccW-1:0]       occ_q, occ_d;
  lfu_pkg::op_e          op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic                  res_hit_q;
  logic [VALUE_BITS-1:0] res_val_q;
  logic                  out_valid_q;
  logic                  out_hit_q;
  logic [lfu_pkg::ReadBits-1:0] out_data_q;
  logic                  accept, out_free;

  // scan chain taps
  logic                  c_hit   [ENTRIES+1];
  logic [IdxW-1:0]       c_hidx  [ENTRIES+1];
  logic [IdxW-1:0]       c_hrank [ENTRIES+1];
  logic [VALUE_BITS-1:0] c_hval  [ENTRIES+1];
  logic                  c_vok   [ENTRIES+1];
  logic [IdxW-1:0]       c_vidx  [ENTRIES+1];
  logic [COUNT_BITS-1:0] c_vcnt  [ENTRIES+1];
  logic [IdxW-1:0]       c_vrank [ENTRIES+1];
  logic                  c_fok   [ENTRIES+1];
  logic [IdxW-1:0]       c_fidx  [ENTRIES+1];

  // update command
  lfu_pkg::cmd_e cmd;
  logic          wr_value, evict;
  logic [IdxW-1:0] slot_idx;
  logic [CmpW-1:0] cap_eff;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == lfu_pkg::ST_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;

  // scan word enters the row empty
  assign c_hit[0]   = 1'b0;
  assign c_hidx[0]  = '0;
  assign c_hrank[0] = '0;
  assign c_hval[0]  = '0;
  assign c_vok[0]   = 1'b0;
  assign c_vidx[0]  = '0;
  assign c_vcnt[0]  = '0;
  assign c_vrank[0] = '0;
  assign c_fok[0]   = 1'b0;
  assign c_fidx[0]  = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell #(
      .ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS),
      .COUNT_BITS(COUNT_BITS), .IDX(g)
    ) u_cell (
      .clk_i, .rst_ni, .key_i(key_q),
      .hit_i(c_hit[g]), .hit_idx_i(c_hidx[g]), .hit_rank_i(c_hrank[g]),
      .hit_value_i(c_hval[g]), .vic_ok_i(c_vok[g]), .vic_idx_i(c_vidx[g]),
      .vic_count_i(c_vcnt[g]), .vic_rank_i(c_vrank[g]),
      .free_ok_i(c_fok[g]), .free_idx_i(c_fidx[g]),
      .hit_o(c_hit[g+1]), .hit_idx_o(c_hidx[g+1]), .hit_rank_o(c_hrank[g+1]),
      .hit_value_o(c_hval[g+1]), .vic_ok_o(c_vok[g+1]), .vic_idx_o(c_vidx[g+1]),
      .vic_count_o(c_vcnt[g+1]), .vic_rank_o(c_vrank[g+1]),
      .free_ok_o(c_fok[g+1]), .free_idx_o(c_fidx[g+1]),
      .cmd_i(cmd), .wr_value_i(wr_value), .evict_i(evict),
      .tgt_idx_i(c_hidx[ENTRIES]), .tgt_rank_i(c_hrank[ENTRIES]),
      .ev_idx_i(c_vidx[ENTRIES]), .ev_rank_i(c_vrank[ENTRIES]),
      .slot_idx_i(slot_idx), .new_value_i(val_q)
    );
  end

  // capacity clamp and the command chosen from the finished scan word
  assign cap_eff = (CmpW'(cap_q) > MaxCap) ? MaxCap : CmpW'(cap_q);

  always_comb begin
    cmd      = lfu_pkg::CMD_NONE;
    wr_value = 1'b0;
    evict    = 1'b0;
    slot_idx = c_fidx[ENTRIES];
    occ_d    = occ_q;
    if (state_q == lfu_pkg::ST_APPLY) begin
      if (op_q == lfu_pkg::OP_GET) begin
        if (c_hit[ENTRIES]) cmd = lfu_pkg::CMD_TOUCH;
      end else if (cap_eff != '0) begin
        if (c_hit[ENTRIES]) begin
          cmd      = lfu_pkg::CMD_TOUCH;
          wr_value = 1'b1;
        end else begin
          evict = (CmpW'(occ_q) >= cap_eff) && c_vok[ENTRIES];
          if (evict && !(c_fok[ENTRIES] && (c_fidx[ENTRIES] < c_vidx[ENTRIES]))) begin
            slot_idx = c_vidx[ENTRIES];
          end
          if (evict || c_fok[ENTRIES]) begin
            cmd   = lfu_pkg::CMD_INSERT;
            occ_d = evict ? occ_q : occ_q + 1'b1;
          end
        end
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      lfu_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (accept) state_d = lfu_pkg::ST_SCAN;
      end
      lfu_pkg::ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIdx) state_d = lfu_pkg::ST_APPLY;
      end
      lfu_pkg::ST_APPLY: begin
        state_d = (op_q == lfu_pkg::OP_GET) ? lfu_pkg::ST_RESP : lfu_pkg::ST_IDLE;
      end
      lfu_pkg::ST_RESP: begin
        if (out_free) state_d = lfu_pkg::ST_IDLE;
      end
      default: state_d = lfu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfu_pkg::ST_IDLE;
      cnt_q       <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      occ_q   <= occ_d;
      if (state_q == lfu_pkg::ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item capture, result capture and output word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= lfu_pkg::op_e'(s_axis_tuser);
      key_q <= s_axis_tdata[KEY_BITS-1:0];
      val_q <= s_axis_tdata[KEY_BITS +: VALUE_BITS];
    end
    if (state_q == lfu_pkg::ST_APPLY) begin
      res_hit_q <= c_hit[ENTRIES];
      res_val_q <= c_hit[ENTRIES] ? c_hval[ENTRIES] : '0;
    end
    if (state_q == lfu_pkg::ST_RESP && out_free) begin
      out_hit_q <= res_hit_q;
      if (VALUE_BITS >= lfu_pkg::ReadBits) begin
        out_data_q <= lfu_pkg::ReadBits'(res_val_q);
      end else begin
        out_data_q <= lfu_pkg::ReadBits'({{lfu_pkg::ReadBits{1'b0}}, res_val_q});
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_hit_q;

endmodule
`default_nettype wire

>>> tb/sv/lfu_cache_lru_tiebreak_tb.sv
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_tb: self-checking bench for the LFU cache
// Drives puts and gets over the stream port and sets the capacity over APB.
// An internal cache predictor computes each get word and checks the output.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak_tb;

  localparam int unsigned NumEntries = 64;
  localparam int unsigned CountMax   = 65535;
  localparam int unsigned CycleLimit = 900000;
  localparam int unsigned PendDepth  = 16;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
  } lookup_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // key [15:0], value [47:16]
  logic        s_axis_tuser = 1'b0;  // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // read_value
  logic        m_axis_tuser;  // hit
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [lfu_pkg::ApbAddrBits-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lfu_cache_lru_tiebreak dut (.*);

  always #6 clk_i = ~clk_i;

  // predictor state
  bit          pm_valid [NumEntries];
  logic [15:0] pm_key   [NumEntries];
  logic [31:0] pm_value [NumEntries];
  int unsigned pm_count [NumEntries];
  int unsigned pm_rank  [NumEntries];
  int unsigned pm_occ;
  int unsigned pm_capacity;

  // expected lookup words, oldest at the read pointer
  lookup_t     pend_words [PendDepth];
  int unsigned pend_wr;
  int unsigned pend_rd;

  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned items_sent;
  int unsigned cycles;
  bit          hold_off;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report(input string what);
    mismatches++;
    $display("mismatch: %s", what);
  endtask

  function automatic int unsigned pend_count();
    return pend_wr - pend_rd;
  endfunction

  function automatic void pend_add(input lookup_t w);
    pend_words[pend_wr % PendDepth] = w;
    pend_wr++;
  endfunction

  function automatic lookup_t pend_take();
    lookup_t w;
    w = pend_words[pend_rd % PendDepth];
    pend_rd++;
    return w;
  endfunction

  function automatic int find_entry(input logic [15:0] key);
    for (int i = 0; i < NumEntries; i++)
      if (pm_valid[i] && pm_key[i] == key) return i;
    return -1;
  endfunction

  // make entry most recent and count one use
  function automatic void count_use(input int e);
    int unsigned r;
    r = pm_rank[e];
    if (pm_count[e] < CountMax) pm_count[e]++;
    for (int i = 0; i < NumEntries; i++)
      if (pm_valid[i] && pm_rank[i] < r) pm_rank[i]++;
    pm_rank[e] = 0;
  endfunction

  // evict least used, oldest on ties
  function automatic void evict_one();
    int v;
    int unsigned r;
    v = -1;
    for (int i = 0; i < NumEntries; i++) begin
      if (!pm_valid[i]) continue;
      if (v < 0 || pm_count[i] < pm_count[v] ||
          (pm_count[i] == pm_count[v] && pm_rank[i] > pm_rank[v])) v = i;
    end
    if (v < 0) return;
    r = pm_rank[v];
    pm_valid[v] = 1'b0;
    for (int i = 0; i < NumEntries; i++)
      if (pm_valid[i] && pm_rank[i] > r) pm_rank[i]--;
    if (pm_occ > 0) pm_occ--;
  endfunction

  function automatic void insert_entry(input logic [15:0] key, input logic [31:0] value);
    int slot;
    slot = -1;
    for (int i = 0; i < NumEntries; i++) begin
      if (!pm_valid[i]) begin
        if (slot < 0) slot = i;
      end else begin
        pm_rank[i]++;
      end
    end
    if (slot < 0) return;
    pm_valid[slot] = 1'b1;
    pm_key[slot] = key;
    pm_value[slot] = value;
    pm_count[slot] = 1;
    pm_rank[slot] = 0;
    pm_occ++;
  endfunction

  function automatic void predict_access(input lfu_pkg::op_e op, input logic [15:0] key,
                                         input logic [31:0] value);
    int unsigned cap;
    int e;
    lookup_t w;
    cap = (pm_capacity > NumEntries) ? NumEntries : pm_capacity;
    e = find_entry(key);
    if (op == lfu_pkg::OP_PUT) begin
      if (cap == 0) return;
      if (e >= 0) begin
        pm_value[e] = value;
        count_use(e);
      end else begin
        if (pm_occ >= cap) evict_one();
        insert_entry(key, value);
      end
    end else begin
      if (e >= 0) begin
        count_use(e);
        w.hit = 1'b1;
        w.read_value = pm_value[e];
      end else begin
        w = '0;
      end
      pend_add(w);
    end
  endfunction

  // drop the input valid between bursts
  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
  endtask

  // send one word, predict on acceptance
  task automatic send_access(input lfu_pkg::op_e op, input logic [15:0] key,
                             input logic [31:0] value, input bit no_gap = 1'b0);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {value, key};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_access(op, key, value);
    items_sent++;
  endtask

  task automatic write_capacity(input logic [31:0] cap);
    idle_input();
    while (pend_count() != 0) @(posedge clk_i);
    repeat (NumEntries + 8) @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= lfu_pkg::AddrCapacity;
    pwdata <= cap;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    pm_capacity = cap & 32'h7f;
  endtask

  // receiver stall and result checking
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pend_count() == 0) begin
        report("result word with nothing expected");
      end else begin
        lookup_t w;
        w = pend_take();
        words_checked++;
        if (m_axis_tuser !== w.hit)
          report($sformatf("hit %b, expected %b", m_axis_tuser, w.hit));
        if (m_axis_tdata !== w.read_value)
          report($sformatf("read_value %h, expected %h", m_axis_tdata, w.read_value));
      end
    end
  end

  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end else begin
        stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
        m_axis_tready <= (stall == 0);
        @(posedge clk_i);
        if (stall != 0) begin
          repeat (stall - 1) @(posedge clk_i);
          m_axis_tready <= 1'b1;
          @(posedge clk_i);
        end
        while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk_i);
      end
    end
  end

  // extremes of key and value, hit and miss
  task automatic test_directed();
    send_access(lfu_pkg::OP_GET, 16'h0000, 32'h0);
    send_access(lfu_pkg::OP_PUT, 16'h0000, 32'h0000_0000);
    send_access(lfu_pkg::OP_PUT, 16'hffff, 32'hffff_ffff);
    send_access(lfu_pkg::OP_PUT, 16'h5555, 32'haaaa_aaaa);
    send_access(lfu_pkg::OP_PUT, 16'haaaa, 32'h5555_5555);
    send_access(lfu_pkg::OP_GET, 16'hffff, 32'h1234_5678);
    send_access(lfu_pkg::OP_GET, 16'h0000, 32'hffff_ffff);
    send_access(lfu_pkg::OP_PUT, 16'hffff, 32'h0000_0001);
    send_access(lfu_pkg::OP_GET, 16'hffff, 32'h0);
    send_access(lfu_pkg::OP_GET, 16'h1234, 32'h0);
    send_access(lfu_pkg::OP_GET, 16'h5555, 32'h0);
    send_access(lfu_pkg::OP_GET, 16'haaaa, 32'h0);
  endtask

  // small capacity: lfu eviction with recency tie-break
  task automatic test_eviction(input logic [31:0] cap, input int unsigned n);
    write_capacity(cap);
    for (int i = 0; i < n; i++) begin
      logic [15:0] k;
      k = 16'($urandom_range(0, 7));
      if ($urandom_range(0, 1)) send_access(lfu_pkg::OP_GET, k, $urandom);
      else send_access(lfu_pkg::OP_PUT, k, $urandom);
    end
  endtask

  // capacity zero: puts ignored, resident entries readable
  task automatic test_zero_capacity();
    write_capacity(0);
    for (int i = 0; i < 20; i++)
      send_access(lfu_pkg::op_e'($urandom_range(0, 1)), 16'($urandom_range(0, 7)),
                  $urandom);
  endtask

  // long hold-off on the result side fills the block
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        int unsigned held;
        held = 0;
        while (held < 400) begin
          @(posedge clk_i);
          held++;
        end
        hold_off = 1'b0;
      end
      for (int i = 0; i < 10; i++)
        send_access(lfu_pkg::OP_GET, 16'($urandom_range(0, 7)), $urandom, 1'b1);
    join
  endtask

  // heavily used entry survives eviction at capacity two
  task automatic test_saturation();
    write_capacity(2);
    send_access(lfu_pkg::OP_PUT, 16'h0042, 32'hdead_beef);
    for (int i = 0; i < 12; i++) send_access(lfu_pkg::OP_GET, 16'h0042, 32'h0, 1'b1);
    send_access(lfu_pkg::OP_PUT, 16'h0043, 32'h1);
    send_access(lfu_pkg::OP_PUT, 16'h0044, 32'h2);
    send_access(lfu_pkg::OP_GET, 16'h0043, 32'h0);
    send_access(lfu_pkg::OP_GET, 16'h0042, 32'h0);
  endtask

  // random mix over narrow and wide key pools
  task automatic test_random(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      logic [15:0] k;
      if ($urandom_range(0, 9) == 0) k = 16'($urandom);
      else k = 16'($urandom_range(0, 95));
      send_access(lfu_pkg::op_e'($urandom_range(0, 1)), k, $urandom);
    end
  endtask

  initial begin
    pm_capacity = 32'(lfu_pkg::CapReset);
    pm_occ = 0;
    pend_wr = 0;
    pend_rd = 0;
    foreach (pm_valid[i]) pm_valid[i] = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(350);
    test_eviction(3, 200);
    test_eviction(1, 100);
    test_zero_capacity();
    test_backpressure();
    test_saturation();
    test_eviction(100, 150);
    test_random(400);
    test_eviction(40, 150);
    test_random(300);
    test_eviction(64, 200);
    idle_input();
    while (pend_count() != 0) @(posedge clk_i);
    repeat (NumEntries + 10) @(posedge clk_i);
    $display("sent %0d puts and gets, checked %0d lookup words", items_sent, words_checked);
    $display("capacities 64, 3, 1, 0, 2, 100, 40 with a long result stall");
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

>>> filelist.f
rtl/lfu_pkg.sv
rtl/lfu_cell.sv
rtl/lfu_cache_lru_tiebreak.sv
tb/sv/lfu_cache_lru_tiebreak_tb.sv
